// ===== rtl/core/lmss_pkg.sv =====
// Shared types and constants of the LED matrix scan sequencer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lmss_pkg;

    // Input item kinds carried on s_tuser.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROW_DWELL  = 2'd0;
    localparam logic [1:0] CFG_REPEAT     = 2'd1;
    localparam logic [1:0] CFG_PAT_COUNT  = 2'd2;

    // Register reset values.
    localparam logic [23:0] ROW_DWELL_RST = 24'd1000;
    localparam logic [7:0]  REPEAT_RST    = 8'd10;
    localparam logic [8:0]  PAT_COUNT_RST = 9'd1;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    // Only 256 entries can ever be addressed through an 8-bit index.
    localparam int unsigned TABLE_ADDR_MAX  = 256;
    localparam logic [8:0]  PAT_COUNT_MAX   = 9'd256;

    localparam logic [2:0]  LAST_ROW   = 3'd4;
    localparam int unsigned SPEED_LSB  = 25;
    localparam int unsigned SPEED_W    = 7;

    typedef struct packed {
        logic [23:0] row_dwell_ticks;
        logic [7:0]  repeat_base;
        logic [8:0]  pattern_count;
    } cfg_t;

    // Table access request: one write port and one read port.
    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_idx;
        logic [31:0] wr_data;
        logic [7:0]  rd_idx;
    } tbl_req_t;

    // Result item, first field in the highest bits.
    typedef struct packed {
        logic [7:0] pattern_index;
        logic [4:0] row_select_n;
        logic [4:0] column_bits;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/lmss_table.sv =====
// Pattern table: synchronous memory with one write and one registered read port.
// Forwards a write that hits the address read in the same cycle, and a write to
// the entry on show onto the display word. Uses lmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmss_table #(
    parameter int unsigned TABLE_DEPTH = lmss_pkg::TABLE_DEPTH_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  lmss_pkg::tbl_req_t     req,
    output logic [31:0]            rd_word,
    output logic [31:0]            show_word
);
    import lmss_pkg::*;

    localparam int unsigned MEM_DEPTH =
        (TABLE_DEPTH > TABLE_ADDR_MAX) ? TABLE_ADDR_MAX : TABLE_DEPTH;
    localparam int unsigned ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [31:0]       mem [MEM_DEPTH];
    logic [31:0]       mem_q_reg;
    logic [31:0]       byp_data_reg;
    logic              byp_hit_reg;
    logic              rd_ok_reg;
    logic [7:0]        shown_idx_reg;
    logic              wr_ok;
    logic              rd_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_ok   = req.wr_en && (32'(req.wr_idx) < 32'(MEM_DEPTH));
    assign rd_ok   = 32'(req.rd_idx) < 32'(MEM_DEPTH);
    assign wr_addr = req.wr_idx[ADDR_W-1:0];
    assign rd_addr = req.rd_idx[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr] <= req.wr_data;
        end
        mem_q_reg    <= mem[rd_addr];
        byp_data_reg <= req.wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            shown_idx_reg <= 8'd0;
        end else begin
            byp_hit_reg   <= wr_ok && (req.wr_idx == req.rd_idx);
            rd_ok_reg     <= rd_ok;
            shown_idx_reg <= req.rd_idx;
        end
    end

    // An entry beyond the table reads as zero.
    assign rd_word = !rd_ok_reg  ? 32'd0 :
                     byp_hit_reg ? byp_data_reg : mem_q_reg;

    // A write request to the entry on show is seen by its own result.
    assign show_word = (wr_ok && (req.wr_idx == shown_idx_reg)) ? req.wr_data : rd_word;

endmodule

`default_nettype wire

// ===== rtl/core/lmss_seq.sv =====
// Scan sequencer: dwell, row, frame and pattern counters, and the display mux.
// Reads the shown entry from lmss_table; uses lmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmss_seq (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 tick,
    input  lmss_pkg::cfg_t      cfg,
    input  wire  [31:0]         word,
    input  wire  [31:0]         show_word,
    output logic [7:0]          rd_idx,
    output lmss_pkg::res_t      disp
);
    import lmss_pkg::*;

    logic [7:0]  shown_reg, shown_next;
    logic [2:0]  row_reg, row_next;
    logic [23:0] dwell_reg, dwell_next;
    logic [14:0] repeats_reg, repeats_next;
    logic        reload_reg, reload_next;

    logic [23:0] dwell_eff;
    logic [8:0]  count_eff;
    logic [23:0] dwell_inc;
    logic [8:0]  idx_inc;
    logic [7:0]  speed_p1;
    logic [14:0] reload_val;
    logic        row_end;
    logic        frame_end;
    logic        pat_end;

    assign dwell_eff = (cfg.row_dwell_ticks == 24'd0) ? 24'd1 : cfg.row_dwell_ticks;
    assign count_eff = (cfg.pattern_count == 9'd0)         ? 9'd1 :
                       (cfg.pattern_count > PAT_COUNT_MAX) ? PAT_COUNT_MAX :
                       cfg.pattern_count;

    assign dwell_inc = dwell_reg + 24'd1;
    assign idx_inc   = {1'b0, shown_reg} + 9'd1;
    assign row_end   = dwell_inc >= dwell_eff;
    assign frame_end = row_end && (row_reg == LAST_ROW);
    assign pat_end   = frame_end && (repeats_reg <= 15'd1);

    // The word of a newly shown entry arrives in the cycle after the change, so the
    // frame count is reloaded then; the next frame end is at least five ticks off.
    assign speed_p1   = {1'b0, word[SPEED_LSB +: SPEED_W]} + 8'd1;
    assign reload_val = 15'({8'd0, cfg.repeat_base} * {8'd0, speed_p1});

    always_comb begin
        shown_next   = shown_reg;
        row_next     = row_reg;
        dwell_next   = dwell_reg;
        repeats_next = repeats_reg;
        reload_next  = 1'b0;
        if (reload_reg) begin
            repeats_next = reload_val;
        end
        if (tick) begin
            if (!row_end) begin
                dwell_next = dwell_inc;
            end else begin
                dwell_next = 24'd0;
                if (!frame_end) begin
                    row_next = row_reg + 3'd1;
                end else begin
                    row_next = 3'd0;
                    if (!pat_end) begin
                        repeats_next = repeats_reg - 15'd1;
                    end else begin
                        shown_next  = (idx_inc >= count_eff) ? 8'd0 : idx_inc[7:0];
                        reload_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg   <= 8'd0;
            row_reg     <= 3'd0;
            dwell_reg   <= 24'd0;
            repeats_reg <= 15'(REPEAT_RST);
            reload_reg  <= 1'b0;
        end else begin
            shown_reg   <= shown_next;
            row_reg     <= row_next;
            dwell_reg   <= dwell_next;
            repeats_reg <= repeats_next;
            reload_reg  <= reload_next;
        end
    end

    // The table is always read at the entry that will be shown after this edge.
    assign rd_idx = shown_next;

    always_comb begin
        disp.pattern_index = shown_reg;
        case (row_reg)
            3'd1: begin
                disp.column_bits  = show_word[9:5];
                disp.row_select_n = 5'b11101;
            end
            3'd2: begin
                disp.column_bits  = show_word[14:10];
                disp.row_select_n = 5'b11011;
            end
            3'd3: begin
                disp.column_bits  = show_word[19:15];
                disp.row_select_n = 5'b10111;
            end
            3'd4: begin
                disp.column_bits  = show_word[24:20];
                disp.row_select_n = 5'b01111;
            end
            default: begin
                disp.column_bits  = show_word[4:0];
                disp.row_select_n = 5'b11110;
            end
        endcase
    end

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= LAST_ROW)
        else $error("row counter left the range of matrix rows");

    a_reload_start: assert property (@(posedge aclk) disable iff (!aresetn)
        reload_reg |-> (row_reg == 3'd0) && (dwell_reg == 24'd0))
        else $error("frame count reload pending outside the start of a frame");

    a_reload_once: assert property (@(posedge aclk) disable iff (!aresetn)
        reload_reg |=> !reload_reg)
        else $error("frame count reload pending for more than one cycle");

endmodule

`default_nettype wire

// ===== rtl/core/lmss_skid.sv =====
// Output register with a skid stage, so the input side keeps moving while a
// result waits. Uses lmss_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module lmss_skid (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  lmss_pkg::res_t      in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output lmss_pkg::res_t      out_data
);
    import lmss_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic accept;
    logic out_free;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (accept) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/led_matrix_scan_sequencer.sv =====
// LED matrix scan sequencer for a multiplexed 5x5 matrix.
// Request stream in on s_*: s_tuser selects a time tick or a table write,
// s_tdata carries the entry index and pattern word of a write.
// Each request gives one result on m_*: column bits, active-low row enable
// and the index of the table entry on show, taken before the tick's update.
// Table writes change no counter; their result repeats the current display.
// Configuration goes through cfg_we/cfg_index/cfg_wdata and must only be
// written while no request is in flight.
// Each result is registered, a stalled one in the skid entry. Throughput: one
// request per clock while s_tready is high; the pattern table is a synchronous
// RAM read every cycle at the next shown entry, with a write to it forwarded.
// Output: result register plus one skid entry; s_tready falls only once both
// are full while m_tready is low, and rises again as soon as one drains.
// Reset: counters and entry index clear, registers return to 1000 ticks dwell,
// base 10 frames and one entry; the frame count starts at ten. Table contents
// stay undefined until written, and no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_scan_sequencer #(
    parameter int unsigned TABLE_DEPTH = lmss_pkg::TABLE_DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Request channel.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [7:0] entry_index, [39:8] entry_word
    input  wire         s_tuser,   // [0] operation
    // Result channel.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [4:0] column_bits, [9:5] row_select_n,
                                   // [17:10] pattern_index, [23:18] zero
    // Configuration write port.
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [23:0] cfg_wdata
);
    import lmss_pkg::*;

    cfg_t     cfg_reg;
    tbl_req_t tbl_req;
    res_t     disp;
    res_t     m_res;
    logic     accept;
    logic     tick;
    logic     [7:0]  rd_idx;
    logic     [31:0] word;
    logic     [31:0] show_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_dwell_ticks <= ROW_DWELL_RST;
            cfg_reg.repeat_base     <= REPEAT_RST;
            cfg_reg.pattern_count   <= PAT_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROW_DWELL: cfg_reg.row_dwell_ticks <= cfg_wdata;
                CFG_REPEAT:    cfg_reg.repeat_base     <= cfg_wdata[7:0];
                CFG_PAT_COUNT: cfg_reg.pattern_count   <= cfg_wdata[8:0];
                default:       ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;
    assign tick   = accept && (s_tuser == OP_TICK);

    assign tbl_req.wr_en   = accept && (s_tuser == OP_WRITE);
    assign tbl_req.wr_idx  = s_tdata[7:0];
    assign tbl_req.wr_data = s_tdata[39:8];
    assign tbl_req.rd_idx  = rd_idx;

    lmss_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (tbl_req),
        .rd_word   (word),
        .show_word (show_word)
    );

    lmss_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (tick),
        .cfg       (cfg_reg),
        .word      (word),
        .show_word (show_word),
        .rd_idx    (rd_idx),
        .disp      (disp)
    );

    lmss_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (disp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    assign m_tdata = {6'd0, m_res};

endmodule

`default_nettype wire

// ===== verif/lmss_display_checker.sv =====
// Scoreboard for the LED matrix scan sequencer: predicts the display for every
// request and compares it with the result stream. Depends on lmss_pkg only.
`timescale 1ns / 1ps

module lmss_display_checker #(
    parameter int unsigned TABLE_DEPTH = lmss_pkg::TABLE_DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [39:0] s_tdata,   // [7:0] entry_index, [39:8] entry_word
    input  wire         s_tuser,   // [0] operation
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [23:0] m_tdata,   // [4:0] column_bits, [9:5] row_select_n,
                                   // [17:10] pattern_index, [23:18] zero
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [23:0] cfg_wdata,
    output int          pending_results,
    output int          mismatch_count
);
    import lmss_pkg::*;

    // Shadow of the sequencer state and its registers.
    logic [31:0] pattern_mem [TABLE_DEPTH];
    logic [7:0]  shown_idx;
    logic [2:0]  row_idx;
    logic [23:0] dwell_cnt;
    logic [14:0] frames_left;
    logic [23:0] dwell_ticks;
    logic [7:0]  repeat_base;
    logic [8:0]  entry_count;

    res_t expected_display [$];
    int   fault_total = 0;

    function automatic logic [31:0] read_pattern(input logic [7:0] idx);
        if (idx < TABLE_DEPTH) begin
            return pattern_mem[idx];
        end
        return 32'd0;
    endfunction

    // What the matrix shows during the current tick, before any counter moves.
    function automatic res_t show_current();
        res_t        shown;
        logic [31:0] word;
        word = read_pattern(shown_idx) >> (5 * row_idx);
        shown.column_bits   = word[4:0];
        shown.row_select_n  = ~(5'b00001 << row_idx);
        shown.pattern_index = shown_idx;
        return shown;
    endfunction

    function automatic void advance_scan();
        logic [23:0] dwell_eff;
        logic [8:0]  span;
        logic [8:0]  next_idx;
        logic [31:0] word;
        logic [31:0] frames;
        dwell_eff = (dwell_ticks == 24'd0) ? 24'd1 : dwell_ticks;
        dwell_cnt = dwell_cnt + 24'd1;
        if (dwell_cnt < dwell_eff) begin
            return;
        end
        dwell_cnt = 24'd0;
        if (row_idx != LAST_ROW) begin
            row_idx = row_idx + 3'd1;
            return;
        end
        row_idx = 3'd0;
        // A frame count of zero or one both mean the frame just ended was the last.
        if (frames_left > 15'd1) begin
            frames_left = frames_left - 15'd1;
            return;
        end
        if (entry_count == 9'd0) begin
            span = 9'd1;
        end else if (entry_count > PAT_COUNT_MAX) begin
            span = PAT_COUNT_MAX;
        end else begin
            span = entry_count;
        end
        next_idx = {1'b0, shown_idx} + 9'd1;
        if (next_idx >= span) begin
            next_idx = 9'd0;
        end
        shown_idx   = next_idx[7:0];
        word        = read_pattern(shown_idx);
        frames      = repeat_base * (32'd1 + word[SPEED_LSB +: SPEED_W]);
        frames_left = frames[14:0];
    endfunction

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            shown_idx   = 8'd0;
            row_idx     = 3'd0;
            dwell_cnt   = 24'd0;
            frames_left = {7'd0, REPEAT_RST};
            dwell_ticks = ROW_DWELL_RST;
            repeat_base = REPEAT_RST;
            entry_count = PAT_COUNT_RST;
            expected_display.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROW_DWELL: dwell_ticks = cfg_wdata;
                    CFG_REPEAT:    repeat_base = cfg_wdata[7:0];
                    CFG_PAT_COUNT: entry_count = cfg_wdata[8:0];
                    default: ;
                endcase
            end
            // Results are checked before this edge's request is predicted, as a
            // result can never belong to a request taken in the same cycle.
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[17:0]);
                if (expected_display.size() == 0) begin
                    if (fault_total < 10) begin
                        $display("%0t: result with no request waiting: col=%b rows=%b entry=%0d",
                                 $realtime, got.column_bits, got.row_select_n,
                                 got.pattern_index);
                    end
                    fault_total++;
                end else begin
                    want = expected_display.pop_front();
                    if (got.column_bits !== want.column_bits
                            || got.row_select_n !== want.row_select_n
                            || got.pattern_index !== want.pattern_index
                            || m_tdata[23:18] !== 6'd0) begin
                        if (fault_total < 10) begin
                            $write("%0t: display mismatch: expected col=%b rows=%b entry=%0d,",
                                   $realtime, want.column_bits, want.row_select_n,
                                   want.pattern_index);
                            $display(" got col=%b rows=%b entry=%0d pad=%h",
                                     got.column_bits, got.row_select_n,
                                     got.pattern_index, m_tdata[23:18]);
                        end
                        fault_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_WRITE) begin
                    if (s_tdata[7:0] < TABLE_DEPTH) begin
                        pattern_mem[s_tdata[7:0]] = s_tdata[39:8];
                    end
                    expected_display.push_back(show_current());
                end else begin
                    expected_display.push_back(show_current());
                    advance_scan();
                end
            end
        end
        pending_results <= expected_display.size();
        mismatch_count  <= fault_total;
    end

endmodule

// ===== verif/led_matrix_scan_sequencer_tb.sv =====
// Top of the LED matrix scan sequencer testbench: clock, reset, requests, register
// writes and the verdict. Uses lmss_pkg, the sequencer and lmss_display_checker.
`timescale 1ns / 1ps

module led_matrix_scan_sequencer_tb;
    import lmss_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic        s_tuser   = OP_TICK;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_ROW_DWELL;
    logic [23:0] cfg_wdata = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    int          pending_results;
    int          mismatch_count;

    // Stimulus bookkeeping: entries may only be shown once they hold a pattern.
    bit          pattern_written [TABLE_ADDR_MAX];
    int          filled_prefix  = 0;
    int          active_count   = 1;
    int          send_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int          idle_cycles    = 0;

    always #1 aclk = ~aclk;

    led_matrix_scan_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lmss_display_checker scan_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly slow patterns so that entries change often; now and then any speed.
    function automatic logic [31:0] random_pattern();
        logic [31:0] speed;
        logic [24:0] leds;
        leds = 25'($urandom());
        if ($urandom_range(99) < 85) begin
            speed = $urandom_range(3);
        end else begin
            speed = $urandom_range(127);
        end
        return {speed[6:0], leds};
    endfunction

    task automatic set_idling(input int send_pct, input int sink_pct);
        send_idle_pct  = send_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic put_request(input logic op, input logic [7:0] idx,
                               input logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {word, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_entry(input logic [7:0] idx, input logic [31:0] word);
        put_request(OP_WRITE, idx, word);
        pattern_written[idx] = 1'b1;
        while (filled_prefix < TABLE_ADDR_MAX && pattern_written[filled_prefix]) begin
            filled_prefix++;
        end
    endtask

    task automatic random_tick();
        put_request(OP_TICK, 8'($urandom_range(255)), $urandom());
    endtask

    // The pending count is registered, so it is polled after s_tvalid has dropped.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    task automatic configure(input logic [23:0] dwell, input logic [7:0] base,
                             input logic [8:0] count);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROW_DWELL;
        cfg_wdata <= dwell;
        @(posedge aclk);
        cfg_index <= CFG_REPEAT;
        cfg_wdata <= {16'd0, base};
        @(posedge aclk);
        cfg_index <= CFG_PAT_COUNT;
        cfg_wdata <= {15'd0, count};
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (count == 9'd0) begin
            active_count = 1;
        end else if (count > PAT_COUNT_MAX) begin
            active_count = TABLE_ADDR_MAX;
        end else begin
            active_count = int'(count);
        end
    endtask

    // Ticks mixed with table writes that extend the filled range, hit the
    // entries in rotation (including the one on show) or land anywhere.
    task automatic run_mix(input int n_items, input int tick_pct);
        logic [7:0] idx;
        int         pick;
        for (int k = 0; k < n_items; k++) begin
            if (k % 41 == 40) begin
                wait_drained();
            end
            if ($urandom_range(99) < tick_pct) begin
                random_tick();
            end else begin
                pick = $urandom_range(9);
                if (pick < 4 && filled_prefix < TABLE_ADDR_MAX) begin
                    idx = 8'(filled_prefix);
                end else if (pick < 8) begin
                    idx = 8'($urandom_range(active_count - 1));
                end else begin
                    idx = 8'($urandom_range(255));
                end
                write_entry(idx, random_pattern());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset register values.
        write_entry(8'd0, 32'h0000_0000);
        put_request(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
        put_request(OP_TICK, 8'h00, 32'h0000_0000);
        write_entry(8'd0, 32'hFFFF_FFFF);
        random_tick();
        write_entry(8'hFF, 32'hFFFF_FFFF);
        write_entry(8'd1, 32'h0000_0F80);
        write_entry(8'd2, {7'd0, 25'h1AB_CDEF});
        write_entry(8'd3, {7'd1, 25'h155_5555});
        write_entry(8'd0, {7'd0, 25'h1FF_FFFF});
        random_tick();
        write_entry(8'd0, {7'd2, 25'h0AA_AAAA});
        random_tick();

        // Zero dwell, zero frame count and zero entry count all act as one.
        configure(24'd0, 8'd0, 9'd0);
        for (int k = 0; k < 10; k++) begin
            random_tick();
        end
        run_mix(60, 85);

        set_idling(46, 0);
        configure(24'd1, 8'd1, 9'((filled_prefix < 8) ? filled_prefix : 8));
        run_mix(50, 70);

        set_idling(0, 46);
        configure(24'd2, 8'd0, 9'($urandom_range(filled_prefix, 1)));
        run_mix(50, 70);

        set_idling(29, 29);
        configure(24'hFF_FFFF, 8'hFF, 9'(filled_prefix));
        run_mix(40, 60);

        set_idling(0, 0);
        configure(24'd1, 8'd1, 9'($urandom_range(filled_prefix, 1)));
        run_mix(40, 75);

        // Extend the filled range well beyond the entries that the remaining
        // phases can reach with an oversized entry count.
        set_idling(29, 29);
        repeat (24) begin
            if (filled_prefix < TABLE_ADDR_MAX) begin
                write_entry(8'(filled_prefix), random_pattern());
            end
        end

        // Oversized entry count with the fastest scan: the entry changes every frame.
        configure(24'd0, 8'd0, 9'h1FF);
        for (int k = 0; k < 40; k++) begin
            random_tick();
        end

        set_idling(0, 46);
        configure(24'd3, 8'd2, PAT_COUNT_MAX);
        run_mix(40, 75);

        set_idling(46, 0);
        configure(24'd1, 8'd0, 9'd257);
        run_mix(40, 80);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
